>>> rtl/assert_macros.svh
// Assertion shorthands for the solver's RTL.
// Clock clk and active-low reset rst_n must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/qrs_pkg.sv
// Shared types, widths and status codes of the quadratic root solver.
// No dependencies.
package qrs_pkg;

  localparam int COEF_W  = 16;               // coefficient width, 8 fraction bits
  localparam int BSQ_W   = 2 * COEF_W;       // b*b and a*c
  localparam int DISC_W  = 2 * COEF_W + 2;   // b*b + 4|ac|
  localparam int RAD_W   = DISC_W + 16;      // discriminant scaled by 2^16
  localparam int ROOT_W  = RAD_W / 2;        // integer square root
  localparam int BASE_W  = COEF_W + 9;       // -b * 2^8
  localparam int NUM_W   = COEF_W + 11;      // base +/- root
  localparam int QUO_W   = NUM_W - 1 + 7;    // |num| * 2^7
  localparam int RES_W   = 32;
  localparam int QDEPTH  = 4;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_ONE   = 2'd1;
  localparam logic [1:0] ST_TWO   = 2'd2;
  localparam logic [1:0] ST_DEGEN = 2'd3;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]              root_status;
    logic signed [RES_W-1:0] root_plus;
    logic signed [RES_W-1:0] root_minus;
    logic                    overflowed;
  } out_beat_t;

  // classified equation, front to square root
  typedef struct packed {
    logic [1:0]               status;
    logic [DISC_W-1:0]        disc;
    logic signed [BASE_W-1:0] base;
    logic signed [COEF_W-1:0] coef_a;
  } job_t;

  // square root done, on to division
  typedef struct packed {
    logic [1:0]               status;
    logic [ROOT_W-1:0]        root;
    logic signed [BASE_W-1:0] base;
    logic signed [COEF_W-1:0] coef_a;
  } sq_job_t;

endpackage

>>> rtl/qrs_front.sv
// Front end: input capture, products, discriminant and classification, job queue.
// Depends on qrs_pkg.
module qrs_front import qrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_beat_t in_data,
  output logic     job_valid,
  input  logic     job_take,
  output job_t     job
);

  localparam int PW = $clog2(QDEPTH);

  logic                     s1_v_r;
  in_beat_t                 s1_r;
  logic                     s2_v_r;
  logic [BSQ_W-1:0]         bsq_r;
  logic signed [BSQ_W-1:0]  prod_r;
  logic signed [BASE_W-1:0] base_r;
  logic signed [COEF_W-1:0] a_r;

  job_t            q_mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     cnt_r;
  logic [PW+1:0]   occ;

  logic [COEF_W-1:0]        babs;
  logic signed [COEF_W:0]   bneg;
  logic [BSQ_W-1:0]         pmag;
  logic [DISC_W-1:0]        four, bsq_e, dsum, ddiff;
  logic                     p_pos;
  job_t                     cls;

  // in-flight items count against queue room so the pipe never stalls
  assign occ     = (PW+2)'(cnt_r) + (PW+2)'(s1_v_r) + (PW+2)'(s2_v_r);
  assign in_full = occ >= (PW+2)'(QDEPTH);

  assign babs = s1_r.coef_b[COEF_W-1] ? (~s1_r.coef_b + 1'b1) : s1_r.coef_b;
  assign bneg = -{s1_r.coef_b[COEF_W-1], s1_r.coef_b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_push && !in_full;
      s2_v_r <= s1_v_r;
    end
    if (in_push && !in_full) begin
      s1_r <= in_data;
    end
    if (s1_v_r) begin
      bsq_r  <= babs * babs;
      prod_r <= s1_r.coef_a * s1_r.coef_c;
      base_r <= {bneg, 8'b0};
      a_r    <= s1_r.coef_a;
    end
  end

  // discriminant and classification
  assign pmag  = prod_r[BSQ_W-1] ? (~prod_r + 1'b1) : prod_r;
  assign four  = {pmag, 2'b00};
  assign bsq_e = {2'b00, bsq_r};
  assign dsum  = bsq_e + four;
  assign ddiff = bsq_e - four;
  assign p_pos = !prod_r[BSQ_W-1] && (prod_r != '0);

  always_comb begin
    cls.base   = base_r;
    cls.coef_a = a_r;
    cls.disc   = p_pos ? ddiff : dsum;
    if (a_r == '0) begin
      cls.status = ST_DEGEN;
    end else if (p_pos && (four > bsq_e)) begin
      cls.status = ST_NONE;
    end else if (cls.disc == '0) begin
      cls.status = ST_ONE;
    end else begin
      cls.status = ST_TWO;
    end
  end

  assign job_valid = cnt_r != '0;
  assign job       = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (s2_v_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (job_take) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(s2_v_r) - (PW+1)'(job_take);
    end
    if (s2_v_r) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> rtl/qrs_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
// Depends on qrs_pkg.
module qrs_sqrt import qrs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    job_valid,
  output logic    job_take,
  input  job_t    job,
  output logic    sq_valid,
  input  logic    sq_take,
  output sq_job_t sq_job
);

  localparam int CW = $clog2(ROOT_W);

  logic                     busy_r, done_r;
  logic [CW-1:0]            cnt_r;
  logic [RAD_W-1:0]         rad_r;
  logic [ROOT_W+1:0]        rem_r;
  logic [ROOT_W-1:0]        root_r;
  logic [1:0]               status_r;
  logic signed [BASE_W-1:0] base_r;
  logic signed [COEF_W-1:0] a_r;

  logic [ROOT_W+1:0] rem_sh, trial;
  logic              ge;

  assign job_take = job_valid && !busy_r && (!done_r || sq_take);
  assign sq_valid = done_r;
  assign sq_job   = '{status: status_r, root: root_r, base: base_r, coef_a: a_r};

  assign rem_sh = {rem_r[ROOT_W-1:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (job_take) begin
      busy_r <= job.status == ST_TWO;
      done_r <= job.status != ST_TWO;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else if (sq_take) begin
      done_r <= 1'b0;
    end

    if (job_take) begin
      status_r <= job.status;
      base_r   <= job.base;
      a_r      <= job.coef_a;
      rad_r    <= {job.disc, 16'b0};
      rem_r    <= '0;
      root_r   <= '0;
      cnt_r    <= CW'(ROOT_W - 1);
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

endmodule

>>> rtl/qrs_div.sv
// Two restoring dividers in lock step for both roots, then saturation; result register.
// Depends on qrs_pkg.
module qrs_div import qrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      sq_valid,
  output logic      sq_take,
  input  sq_job_t   sq_job,
  output logic      out_empty,
  input  logic      out_pop,
  output out_beat_t out_data
);

  localparam int CW = $clog2(QUO_W);
  localparam int MW = (QUO_W > RES_W + 1) ? QUO_W : RES_W + 1;
  localparam logic [MW-1:0] LIM_POS = MW'(64'h7FFF_FFFF);
  localparam logic [MW-1:0] LIM_NEG = MW'(64'h8000_0000);

  logic                busy_r, fin_r, done_r;
  logic [CW-1:0]       cnt_r;
  logic [COEF_W-1:0]   dvs_r;
  logic [QUO_W-1:0]    dvd_r [2];
  logic [COEF_W:0]     rem_r [2];
  logic                neg_r [2];
  logic [1:0]          status_r;
  logic [RES_W-1:0]    res_r [2];
  logic                ovf_r;

  logic signed [NUM_W-1:0] num [2];
  logic [NUM_W-1:0]        mag [2];
  logic [COEF_W:0]         rem_sh [2];
  logic                    ge [2];
  logic [MW-1:0]           qx [2];
  logic [RES_W-1:0]        sat [2];
  logic                    over [2];
  logic [COEF_W-1:0]       aabs;

  assign sq_take   = sq_valid && !busy_r && !fin_r && (!done_r || out_pop);
  assign out_empty = !done_r;
  assign out_data  = '{root_status: status_r, root_plus: res_r[0], root_minus: res_r[1],
                       overflowed: ovf_r};

  assign aabs = sq_job.coef_a[COEF_W-1] ? (~sq_job.coef_a + 1'b1) : sq_job.coef_a;

  always_comb begin
    num[0] = NUM_W'(sq_job.base) + $signed({2'b00, sq_job.root});
    num[1] = NUM_W'(sq_job.base) - $signed({2'b00, sq_job.root});
    for (int i = 0; i < 2; i++) begin
      mag[i]    = num[i][NUM_W-1] ? (~num[i] + 1'b1) : num[i];
      rem_sh[i] = {rem_r[i][COEF_W-1:0], dvd_r[i][QUO_W-1]};
      ge[i]     = rem_sh[i] >= {1'b0, dvs_r};
      qx[i]     = MW'(dvd_r[i]);
      if (neg_r[i]) begin
        over[i] = qx[i] > LIM_NEG;
        sat[i]  = over[i] ? 32'h8000_0000 : RES_W'(~qx[i] + 1'b1);
      end else begin
        over[i] = qx[i] > LIM_POS;
        sat[i]  = over[i] ? 32'h7FFF_FFFF : RES_W'(qx[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (sq_take) begin
      busy_r <= (sq_job.status == ST_ONE) || (sq_job.status == ST_TWO);
      done_r <= (sq_job.status == ST_NONE) || (sq_job.status == ST_DEGEN);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end else if (fin_r) begin
      fin_r  <= 1'b0;
      done_r <= 1'b1;
    end else if (out_pop) begin
      done_r <= 1'b0;
    end

    if (sq_take) begin
      status_r <= sq_job.status;
      dvs_r    <= aabs;
      cnt_r    <= CW'(QUO_W - 1);
      res_r[0] <= '0;
      res_r[1] <= '0;
      ovf_r    <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        dvd_r[i] <= {mag[i][NUM_W-2:0], 7'b0};
        rem_r[i] <= '0;
        neg_r[i] <= num[i][NUM_W-1] ^ sq_job.coef_a[COEF_W-1];
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      for (int i = 0; i < 2; i++) begin
        rem_r[i] <= ge[i] ? (rem_sh[i] - {1'b0, dvs_r}) : rem_sh[i];
        dvd_r[i] <= {dvd_r[i][QUO_W-2:0], ge[i]};
      end
    end else if (fin_r) begin
      res_r[0] <= sat[0];
      res_r[1] <= sat[1];
      ovf_r    <= over[0] || over[1];
    end
  end

endmodule

>>> rtl/quadratic_root_solver.sv
// Quadratic root solver top level: front end, square root and divider back end.
// Depends on qrs_pkg, qrs_front, qrs_sqrt, qrs_div and assert_macros.svh.
//
// Usage:
//  - Input queue port: present a, b, c (signed Q8.8) on in_data, raise in_push;
//    a beat is taken on an edge with in_push high and in_full low.
//  - Result queue port: while out_empty is low the oldest result sits on
//    out_data (status, two Q16.16 roots, saturation flag); out_pop takes it.
//  - Front end: capture and product registers, then classification into a
//    four-entry job queue. in_full counts queued and in-flight beats.
//  - Square root: one root bit a cycle, ROOT_W (25) root bits in all,
//    run only when the discriminant is positive.
//  - Divider: both roots in parallel, one quotient bit a cycle, QUO_W (33)
//    quotient bits after a load, then saturation; it sets the throughput
//    for beats with one or two real roots. No-root and a-is-zero beats
//    skip the square root and division loops.
//  - Reset (synchronous, rst_n low) empties every stage and queue.
//  - A stalled result holds in the divider's result register; square root holds
//    its finished result, the front end carries on until its queue fills, then in_full rises.
`include "assert_macros.svh"
module quadratic_root_solver import qrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_beat_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_beat_t out_data
);

  logic    job_valid, job_take;
  job_t    job;
  logic    sq_valid, sq_take;
  sq_job_t sq_job;

  qrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job)
  );

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job),
    .sq_valid  (sq_valid),
    .sq_take   (sq_take),
    .sq_job    (sq_job)
  );

  qrs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .sq_valid  (sq_valid),
    .sq_take   (sq_take),
    .sq_job    (sq_job),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // no-root and degenerate beats carry zero roots
  `QRS_ASSERT_NOW(a_zero_roots, !out_empty && (out_data.root_status == ST_NONE || out_data.root_status == ST_DEGEN), out_data.root_plus == '0 && out_data.root_minus == '0 && !out_data.overflowed, "absent roots not zero")
  // a double root gives identical roots
  `QRS_ASSERT_NOW(a_double_root, !out_empty && out_data.root_status == ST_ONE, out_data.root_plus == out_data.root_minus, "double root mismatch")
  // finished square root holds while the divider is busy
  `QRS_ASSERT_NEXT(a_sq_hold, sq_valid && !sq_take, sq_valid && $stable(sq_job), "square root result lost")

endmodule
